// File: hw/rtl/clr_pkg.sv
// clr_pkg: shared codes for the clipped line rasterizer.
// Holds result kinds, outcode bits, register indexes and fixed field widths.
// No dependencies.
package clr_pkg;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_PIXEL  = 2'd2,
        KIND_IDLE   = 2'd3
    } kind_t;

    // Request kinds carried on the input tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Cohen-Sutherland outcode bits.
    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Fixed widths.
    localparam int PIX_BITS   = 11;
    localparam int DIM_BITS   = 12;
    localparam int INDEX_BITS = 22;
    localparam int COLOR_BITS = 16;
    localparam int PASS_LIMIT = 16;

    localparam logic [DIM_BITS-1:0] DIM_MAX = 12'd2048;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET = 12'd800;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

endpackage

// File: hw/rtl/clipped_line_rasterizer.sv
// clipped_line_rasterizer: clips a line to the screen and steps it pixel by pixel.
// Depends on clr_pkg for kinds, outcode bits and register indexes.
//
// Usage:
//   s_axis carries requests. tuser = 0 starts a line (tdata holds start_x,
//   start_y, end_x, end_y, pen_color), tuser = 1 asks for the next pixel.
//   m_axis returns one result per request: tuser is the kind (accepted,
//   rejected, pixel, idle), tdata holds pixel_x, pixel_y, pixel_index,
//   pixel_color, tlast marks the last pixel of the line.
//   cfg writes screen_width (index 0) or screen_height (index 1); write it
//   only while no request is in flight.
// Sequencing:
//   A step result is registered and appears in the cycle after its transaction;
//   steps stream at one pixel per cycle while m_axis does not stall.
//   A start runs the clip sequencer: each clip pass is an evaluate step, a
//   shift-add multiply and a restoring divide on one shared adder, and a move
//   step; at most 16 passes plus a final evaluate, a setup and a result step.
// Reset clears the line state and the output valid, kind and last, and loads the
// screen size 800 x 480. When m_axis stalls, the result register holds and
// s_axis_tready stays low until it drains.
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    // Request channel
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y (COORD_BITS each), pen_color (16), zero pad
    input  logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic s_axis_tuser,
    // Result channel
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pixel_x (11), pixel_y (11), pixel_index (22), pixel_color (16), zero pad
    output logic [63:0] m_axis_tdata,
    // kind
    output logic [1:0] m_axis_tuser,
    output logic m_axis_tlast,
    // Configuration write channel
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data
);

    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int AW = P + 1;
    localparam int CW = $clog2(P);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_MOVE,
        ST_SETUP,
        ST_DONE
    } state_t;

    function automatic logic [3:0] outcode(input logic signed [D-1:0] x,
                                           input logic signed [D-1:0] y,
                                           input logic signed [D-1:0] w,
                                           input logic signed [D-1:0] h);
        logic [3:0] c;
        c = 4'd0;
        if (x < 0)
            c = c | OC_LEFT;
        else if (x >= w)
            c = c | OC_RIGHT;
        if (y < 0)
            c = c | OC_TOP;
        else if (y >= h)
            c = c | OC_BOTTOM;
        return c;
    endfunction

    function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
        return v[D-1] ? D'(-v) : D'(v);
    endfunction

    state_t state_reg;

    // Configuration
    logic [DIM_BITS-1:0] width_reg, height_reg;

    // Clip sequencer
    logic signed [D-1:0] x0_reg, y0_reg, x1_reg, y1_reg, base_reg;
    logic [3:0] c0_reg, c1_reg, edge_reg;
    logic [4:0] pass_reg;
    logic move1_reg, neg_reg;
    logic [D-1:0] mplier_reg, dvsr_reg, rem_reg;
    logic [P-1:0] mcand_reg, prod_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [COLOR_BITS-1:0] pend_color_reg;
    logic ok_reg;

    // Line state
    logic line_active_reg;
    logic [PIX_BITS-1:0] cur_col_reg, cur_row_reg, stop_col_reg, stop_row_reg;
    logic [PIX_BITS-1:0] delta_col_reg, delta_row_reg;
    logic col_neg_reg, row_neg_reg, x_major_reg;
    logic signed [DIM_BITS-1:0] err_reg;
    logic [COLOR_BITS-1:0] line_color_reg;

    // Output register
    logic m_valid_reg, out_last_reg;
    kind_t out_kind_reg;
    logic [PIX_BITS-1:0] out_x_reg, out_y_reg;
    logic [INDEX_BITS-1:0] out_idx_reg;
    logic [COLOR_BITS-1:0] out_color_reg;

    // Effective screen size, clamped to 1..2048
    logic [DIM_BITS-1:0] eff_w, eff_h;
    logic signed [D-1:0] w_s, h_s, wm1_s, hm1_s;

    always_comb
    begin
        eff_w = (width_reg == '0) ? DIM_BITS'(1) :
                (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
        eff_h = (height_reg == '0) ? DIM_BITS'(1) :
                (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
        w_s   = signed'({{(D-DIM_BITS){1'b0}}, eff_w});
        h_s   = signed'({{(D-DIM_BITS){1'b0}}, eff_h});
        wm1_s = w_s - D'(1);
        hm1_s = h_s - D'(1);
    end

    // Request field extraction
    logic signed [D-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [COLOR_BITS-1:0] in_color;

    always_comb
    begin
        in_x0 = signed'({s_axis_tdata[COORD_BITS-1], s_axis_tdata[COORD_BITS-1:0]});
        in_y0 = signed'({s_axis_tdata[2*COORD_BITS-1],
                         s_axis_tdata[2*COORD_BITS-1:COORD_BITS]});
        in_x1 = signed'({s_axis_tdata[3*COORD_BITS-1],
                         s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]});
        in_y1 = signed'({s_axis_tdata[4*COORD_BITS-1],
                         s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]});
        in_color = s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    end

    // Clip pass setup: pick the edge and the multiply/divide operands
    logic [3:0] ev_code, ev_edge;
    logic signed [D-1:0] ev_dx, ev_dy, ev_a, ev_b, ev_d, ev_base;

    always_comb
    begin
        ev_code = (c0_reg != 4'd0) ? c0_reg : c1_reg;
        ev_dx   = x1_reg - x0_reg;
        ev_dy   = y1_reg - y0_reg;
        priority if ((ev_code & OC_BOTTOM) != 4'd0)
        begin
            ev_edge = OC_BOTTOM;
            ev_a = ev_dx;  ev_b = hm1_s - y0_reg;  ev_d = ev_dy;  ev_base = x0_reg;
        end
        else if ((ev_code & OC_TOP) != 4'd0)
        begin
            ev_edge = OC_TOP;
            ev_a = ev_dx;  ev_b = -y0_reg;  ev_d = ev_dy;  ev_base = x0_reg;
        end
        else if ((ev_code & OC_RIGHT) != 4'd0)
        begin
            ev_edge = OC_RIGHT;
            ev_a = ev_dy;  ev_b = wm1_s - x0_reg;  ev_d = ev_dx;  ev_base = y0_reg;
        end
        else
        begin
            ev_edge = OC_LEFT;
            ev_a = ev_dy;  ev_b = -x0_reg;  ev_d = ev_dx;  ev_base = y0_reg;
        end
    end

    // Shared adder: shift-add multiply step or restoring divide step
    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic alu_sub;
    logic [D:0] div_trial;

    always_comb
    begin
        div_trial = {rem_reg, quo_reg[P-1]};
        alu_sub   = (state_reg == ST_DIV);
        if (alu_sub)
        begin
            alu_a = AW'(div_trial);
            alu_b = ~AW'(dvsr_reg);
        end
        else
        begin
            alu_a = AW'(prod_reg);
            alu_b = AW'(mcand_reg);
        end
        alu_sum = alu_a + alu_b + AW'(alu_sub);
    end

    // New endpoint after a clip pass
    logic signed [D-1:0] mv_q, mv_new, mv_x, mv_y;

    always_comb
    begin
        mv_q   = signed'(quo_reg[D-1:0]);
        mv_new = base_reg + (neg_reg ? -mv_q : mv_q);
        if (edge_reg == OC_BOTTOM || edge_reg == OC_TOP)
        begin
            mv_x = mv_new;
            mv_y = (edge_reg == OC_BOTTOM) ? hm1_s : '0;
        end
        else
        begin
            mv_y = mv_new;
            mv_x = (edge_reg == OC_RIGHT) ? wm1_s : '0;
        end
    end

    // Line setup from the clipped endpoints
    logic signed [D-1:0] su_dx, su_dy;
    logic [D-1:0] su_adx, su_ady;
    logic su_major;

    always_comb
    begin
        su_dx    = x1_reg - x0_reg;
        su_dy    = y1_reg - y0_reg;
        su_adx   = mag(su_dx);
        su_ady   = mag(su_dy);
        su_major = (su_adx >= su_ady);
    end

    // Bresenham step
    logic st_fin;
    logic [DIM_BITS+PIX_BITS-1:0] st_prod;
    logic [INDEX_BITS-1:0] st_idx;
    logic signed [DIM_BITS:0] st_err;
    logic signed [DIM_BITS-1:0] err_next;
    logic [PIX_BITS-1:0] col_next, row_next, col_adv, row_adv;

    always_comb
    begin
        st_prod = cur_row_reg * width_reg;
        st_idx  = INDEX_BITS'(st_prod + (DIM_BITS+PIX_BITS)'(cur_col_reg));
        st_fin  = x_major_reg ? (cur_col_reg == stop_col_reg)
                              : (cur_row_reg == stop_row_reg);
        col_adv = col_neg_reg ? cur_col_reg - PIX_BITS'(1) : cur_col_reg + PIX_BITS'(1);
        row_adv = row_neg_reg ? cur_row_reg - PIX_BITS'(1) : cur_row_reg + PIX_BITS'(1);
        col_next = cur_col_reg;
        row_next = cur_row_reg;
        if (x_major_reg)
        begin
            st_err = (DIM_BITS+1)'(err_reg) - signed'({2'b00, delta_row_reg});
            if (st_err < 0)
            begin
                row_next = row_adv;
                st_err   = st_err + signed'({2'b00, delta_col_reg});
            end
            col_next = col_adv;
        end
        else
        begin
            st_err = (DIM_BITS+1)'(err_reg) - signed'({2'b00, delta_col_reg});
            if (st_err < 0)
            begin
                col_next = col_adv;
                st_err   = st_err + signed'({2'b00, delta_row_reg});
            end
            row_next = row_adv;
        end
        err_next = st_err[DIM_BITS-1:0];
    end

    logic s_fire, out_free, out_load;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // A step result or a start verdict loads the output register
    assign out_load = (s_fire && s_axis_tuser == REQ_STEP)
                      || (state_reg == ST_DONE && out_free);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'd0, out_color_reg, out_idx_reg, out_y_reg, out_x_reg};

    // Sequencer, line state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            line_active_reg <= 1'b0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            stop_col_reg    <= '0;
            stop_row_reg    <= '0;
            delta_col_reg   <= '0;
            delta_row_reg   <= '0;
            col_neg_reg     <= 1'b0;
            row_neg_reg     <= 1'b0;
            x_major_reg     <= 1'b0;
            err_reg         <= '0;
            line_color_reg  <= '0;
            m_valid_reg     <= 1'b0;
            out_kind_reg    <= KIND_IDLE;
            out_last_reg    <= 1'b0;
            pass_reg        <= '0;
            cnt_reg         <= '0;
            ok_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire && s_axis_tuser == REQ_START)
                    begin
                        line_active_reg <= 1'b0;
                        x0_reg <= in_x0;
                        y0_reg <= in_y0;
                        x1_reg <= in_x1;
                        y1_reg <= in_y1;
                        c0_reg <= outcode(in_x0, in_y0, w_s, h_s);
                        c1_reg <= outcode(in_x1, in_y1, w_s, h_s);
                        pend_color_reg <= in_color;
                        pass_reg <= '0;
                        state_reg <= ST_EVAL;
                    end
                    else if (s_fire)
                    begin
                        if (!line_active_reg)
                        begin
                            out_kind_reg  <= KIND_IDLE;
                            out_x_reg     <= '0;
                            out_y_reg     <= '0;
                            out_idx_reg   <= '0;
                            out_color_reg <= '0;
                            out_last_reg  <= 1'b0;
                        end
                        else
                        begin
                            out_kind_reg  <= KIND_PIXEL;
                            out_x_reg     <= cur_col_reg;
                            out_y_reg     <= cur_row_reg;
                            out_idx_reg   <= st_idx;
                            out_color_reg <= line_color_reg;
                            out_last_reg  <= st_fin;
                            if (st_fin)
                                line_active_reg <= 1'b0;
                            else
                            begin
                                cur_col_reg <= col_next;
                                cur_row_reg <= row_next;
                                err_reg     <= err_next;
                            end
                        end
                    end
                end

                ST_EVAL:
                begin
                    if (pass_reg == 5'(PASS_LIMIT))
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else if ((c0_reg | c1_reg) == 4'd0)
                        state_reg <= ST_SETUP;
                    else if ((c0_reg & c1_reg) != 4'd0 || ev_d == '0)
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        edge_reg   <= ev_edge;
                        move1_reg  <= (c0_reg == 4'd0);
                        base_reg   <= ev_base;
                        neg_reg    <= ev_a[D-1] ^ ev_b[D-1] ^ ev_d[D-1];
                        mplier_reg <= mag(ev_a);
                        mcand_reg  <= P'(mag(ev_b));
                        prod_reg   <= '0;
                        dvsr_reg   <= mag(ev_d);
                        cnt_reg    <= '0;
                        state_reg  <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    if (mplier_reg[0])
                        prod_reg <= alu_sum[P-1:0];
                    mplier_reg <= mplier_reg >> 1;
                    mcand_reg  <= mcand_reg << 1;
                    cnt_reg    <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(D-1))
                    begin
                        quo_reg   <= mplier_reg[0] ? alu_sum[P-1:0] : prod_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    // borrow clear means the divisor fits
                    if (!alu_sum[AW-1])
                    begin
                        rem_reg <= alu_sum[D-1:0];
                        quo_reg <= {quo_reg[P-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_trial[D-1:0];
                        quo_reg <= {quo_reg[P-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(P-1))
                        state_reg <= ST_MOVE;
                end

                ST_MOVE:
                begin
                    if (move1_reg)
                    begin
                        x1_reg <= mv_x;
                        y1_reg <= mv_y;
                        c1_reg <= outcode(mv_x, mv_y, w_s, h_s);
                    end
                    else
                    begin
                        x0_reg <= mv_x;
                        y0_reg <= mv_y;
                        c0_reg <= outcode(mv_x, mv_y, w_s, h_s);
                    end
                    pass_reg  <= pass_reg + 5'd1;
                    state_reg <= ST_EVAL;
                end

                ST_SETUP:
                begin
                    col_neg_reg    <= su_dx[D-1];
                    row_neg_reg    <= su_dy[D-1];
                    cur_col_reg    <= x0_reg[PIX_BITS-1:0];
                    cur_row_reg    <= y0_reg[PIX_BITS-1:0];
                    stop_col_reg   <= x1_reg[PIX_BITS-1:0];
                    stop_row_reg   <= y1_reg[PIX_BITS-1:0];
                    delta_col_reg  <= su_adx[PIX_BITS-1:0];
                    delta_row_reg  <= su_ady[PIX_BITS-1:0];
                    x_major_reg    <= su_major;
                    err_reg        <= signed'({2'b00, su_major ? su_adx[PIX_BITS-1:1]
                                                               : su_ady[PIX_BITS-1:1]});
                    line_color_reg <= pend_color_reg;
                    line_active_reg <= 1'b1;
                    ok_reg         <= 1'b1;
                    state_reg      <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= ok_reg ? KIND_ACCEPT : KIND_REJECT;
                        out_x_reg     <= '0;
                        out_y_reg     <= '0;
                        out_idx_reg   <= '0;
                        out_color_reg <= '0;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: tb/sv/clipped_line_rasterizer_tb.sv
// clipped_line_rasterizer_tb: self-checking testbench for the clipped line rasterizer.
// Drives directed and random line/step transactions with a behavioral predictor.
// Depends on clr_pkg and clipped_line_rasterizer.
module clipped_line_rasterizer_tb;
    import clr_pkg::*;

    localparam int CB = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_GOAL = 2000;
    localparam int PHASES = 6;

    typedef struct {
        kind_t       kind;
        logic [10:0] px;
        logic [10:0] py;
        logic [21:0] idx;
        logic [15:0] col;
        logic        last;
    } pixel_res_t;

    typedef struct {
        logic               req;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [15:0]        color;
        bit                 typed;
        kind_t              kind;
    } line_req_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [DIM_BITS-1:0] cfg_data;

    clipped_line_rasterizer #(.COORD_BITS(CB)) dut (.*);

    // Predictor state
    logic [11:0] scr_w;
    logic [11:0] scr_h;
    bit          drawing;
    logic [10:0] cur_c, cur_r, stop_c, stop_r, dcol, drow;
    bit          cneg, rneg, xmajor;
    int          err_acc;
    logic [15:0] ink;

    pixel_res_t pending_pixels[$];
    int fail_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_dim(logic [11:0] r);
        if (r == 0) return 1;
        if (r > 2048) return 2048;
        return longint'(r);
    endfunction

    function automatic logic [3:0] region(longint x, longint y, longint w, longint h);
        logic [3:0] c;
        c = 4'd0;
        if (x < 0) c |= OC_LEFT;
        else if (x >= w) c |= OC_RIGHT;
        if (y < 0) c |= OC_TOP;
        else if (y >= h) c |= OC_BOTTOM;
        return c;
    endfunction

    function automatic logic [10:0] walk(logic [10:0] v, bit neg);
        return neg ? v - 11'd1 : v + 11'd1;
    endfunction

    // Clip a new line and load the stepper
    function automatic pixel_res_t clip_line(line_req_t it);
        pixel_res_t res;
        longint w, h, x0, y0, x1, y1, dx, dy, nx, ny;
        logic [3:0] c0, c1, c;
        bit ok;
        res = '{KIND_REJECT, 0, 0, 0, 0, 0};
        w = clamp_dim(scr_w);
        h = clamp_dim(scr_h);
        x0 = it.sx; y0 = it.sy; x1 = it.ex; y1 = it.ey;
        c0 = region(x0, y0, w, h);
        c1 = region(x1, y1, w, h);
        ok = 0;
        drawing = 0;
        for (int pass = 0; pass < PASS_LIMIT; pass++)
        begin
            if ((c0 | c1) == 0)
            begin
                ok = 1;
                break;
            end
            if ((c0 & c1) != 0) break;
            c = (c0 != 0) ? c0 : c1;
            dx = x1 - x0;
            dy = y1 - y0;
            if (c & OC_BOTTOM)
            begin
                if (dy == 0) break;
                nx = x0 + (dx * (h - 1 - y0)) / dy;
                ny = h - 1;
            end
            else if (c & OC_TOP)
            begin
                if (dy == 0) break;
                nx = x0 + (dx * (0 - y0)) / dy;
                ny = 0;
            end
            else if (c & OC_RIGHT)
            begin
                if (dx == 0) break;
                ny = y0 + (dy * (w - 1 - x0)) / dx;
                nx = w - 1;
            end
            else
            begin
                if (dx == 0) break;
                ny = y0 + (dy * (0 - x0)) / dx;
                nx = 0;
            end
            if (c0 != 0)
            begin
                x0 = nx; y0 = ny; c0 = region(x0, y0, w, h);
            end
            else
            begin
                x1 = nx; y1 = ny; c1 = region(x1, y1, w, h);
            end
        end
        if (!ok) return res;
        dx = x1 - x0;
        dy = y1 - y0;
        cneg = dx < 0;
        rneg = dy < 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        cur_c = x0[10:0]; cur_r = y0[10:0];
        stop_c = x1[10:0]; stop_r = y1[10:0];
        dcol = dx[10:0]; drow = dy[10:0];
        xmajor = dx >= dy;
        err_acc = int'(xmajor ? dcol : drow) / 2;
        ink = it.color;
        drawing = 1;
        res.kind = KIND_ACCEPT;
        return res;
    endfunction

    // Emit the next pixel of the current line
    function automatic pixel_res_t next_pixel();
        pixel_res_t res;
        logic [43:0] prod;
        bit fin;
        res = '{KIND_IDLE, 0, 0, 0, 0, 0};
        if (!drawing) return res;
        prod = cur_r * scr_w + cur_c;
        fin = xmajor ? (cur_c == stop_c) : (cur_r == stop_r);
        res = '{KIND_PIXEL, cur_c, cur_r, prod[21:0], ink, fin};
        if (fin)
        begin
            drawing = 0;
            return res;
        end
        if (xmajor)
        begin
            err_acc -= int'(drow);
            if (err_acc < 0)
            begin
                cur_r = walk(cur_r, rneg);
                err_acc += int'(dcol);
            end
            cur_c = walk(cur_c, cneg);
        end
        else
        begin
            err_acc -= int'(dcol);
            if (err_acc < 0)
            begin
                cur_c = walk(cur_c, cneg);
                err_acc += int'(drow);
            end
            cur_r = walk(cur_r, rneg);
        end
        return res;
    endfunction

    // Send one request; predict its result once it is accepted
    task automatic send_req(line_req_t it);
        pixel_res_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.req;
        s_axis_tdata = {it.color, it.ey, it.ex, it.sy, it.sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = (it.req == REQ_START) ? clip_line(it) : next_pixel();
        if (it.typed) res = '{it.kind, 0, 0, 0, 0, 0};
        pending_pixels.push_back(res);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WIDTH) scr_w = val;
        else scr_h = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_coord(longint dim);
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * dim) - dim / 2);
    endfunction

    // Receiver stalls
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Result check and watchdog
    always @(posedge clk)
    begin
        pixel_res_t want;
        if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready
            || cfg_valid && cfg_ready)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("kind: expected %0d actual %0d", want.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[10:0] !== want.px)
                begin
                    $error("pixel_x: expected %0d actual %0d", want.px, m_axis_tdata[10:0]);
                    fail_count++;
                end
                if (m_axis_tdata[21:11] !== want.py)
                begin
                    $error("pixel_y: expected %0d actual %0d", want.py, m_axis_tdata[21:11]);
                    fail_count++;
                end
                if (m_axis_tdata[43:22] !== want.idx)
                begin
                    $error("pixel_index: expected %0d actual %0d", want.idx,
                        m_axis_tdata[43:22]);
                    fail_count++;
                end
                if (m_axis_tdata[59:44] !== want.col)
                begin
                    $error("pixel_color: expected %h actual %h", want.col,
                        m_axis_tdata[59:44]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d actual %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        line_req_t rows[$];
        line_req_t it;
        logic [11:0] phase_w[PHASES];
        logic [11:0] phase_h[PHASES];
        int items;
        int steps;
        longint w, h;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_START;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        send_idle_pct = 10;
        recv_idle_pct = 82;
        fail_count = 0;
        idle_cycles = 0;
        scr_w = WIDTH_RESET;
        scr_h = HEIGHT_RESET;
        drawing = 0;
        cur_c = 0; cur_r = 0; stop_c = 0; stop_r = 0; dcol = 0; drow = 0;
        cneg = 0; rneg = 0; xmajor = 0; err_acc = 0; ink = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows at the reset screen size
        rows = '{
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 1, KIND_IDLE},
            '{REQ_START, 0, 0, 799, 479, 16'h1234, 1, KIND_ACCEPT},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_START, -32768, -32768, -1, -1, 16'h0000, 1, KIND_REJECT},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 1, KIND_IDLE},
            '{REQ_START, 32767, 32767, 32767, -32768, 16'hffff, 1, KIND_REJECT},
            '{REQ_START, -100, 240, 900, 240, 16'hffff, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_START, 5, 5, 5, 5, 16'h0000, 1, KIND_ACCEPT},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 1, KIND_IDLE},
            '{REQ_START, 400, -50, 410, 600, 16'h07e0, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_START, -40, 500, 900, -30, 16'hf800, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_START, 799, 0, 0, 479, 16'h001f, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE},
            '{REQ_STEP, 0, 0, 0, 0, 16'h0000, 0, KIND_IDLE}
        };
        foreach (rows[i])
            send_req(rows[i]);

        // Screen sizes per phase; out-of-range values clamp, line state carries over
        phase_w = '{12'd1, 12'd2048, 12'd4095, 12'd64, 12'd3, 12'd800};
        phase_h = '{12'd1, 12'd2048, 12'd0, 12'd48, 12'd2000, 12'd480};
        items = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_WIDTH, phase_w[p]);
            write_reg(REG_HEIGHT, phase_h[p]);
            if (p / 2 == 1)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 10;
            end
            else if (p / 2 == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = clamp_dim(scr_w);
            h = clamp_dim(scr_h);
            while (items < (p + 1) * ITEM_GOAL / PHASES)
            begin
                it = '{REQ_START, pick_coord(w), pick_coord(h), pick_coord(w),
                    pick_coord(h), 16'($urandom), 0, KIND_IDLE};
                // Occasional stray step in place of a start, whether or not a line is active
                if ($urandom_range(9) == 0)
                    it.req = REQ_STEP;
                send_req(it);
                items++;
                steps = 0;
                while (drawing && steps < 60)
                begin
                    it.req = REQ_STEP;
                    it.sx = 16'($urandom);
                    send_req(it);
                    items++;
                    steps++;
                end
                // Sometimes step past the end, sometimes abandon early
                for (int k = $urandom_range(2); k > 0; k--)
                begin
                    it.req = REQ_STEP;
                    send_req(it);
                    items++;
                end
            end
        end

        // Drain
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
